[rtl/wps_pkg.sv]
// Shared types and constants for the WAV PCM stream decoder.
package wps_pkg;

  // Event kinds, carried on the output tuser
  localparam logic [1:0] EVT_PCM = 2'd0;
  localparam logic [1:0] EVT_FMT = 2'd1;
  localparam logic [1:0] EVT_END = 2'd2;
  localparam logic [1:0] EVT_ERR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_TAG      = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd2;
  localparam logic [2:0] ERR_CHANNELS = 3'd3;
  localparam logic [2:0] ERR_NO_FMT   = 3'd4;

  // Chunk tags as they sit in a little-endian 32-bit shift register
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [14:0] VOLUME_RESET = 15'd8192;
  localparam int          Q_SHIFT      = 15;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified event between the parser and the output stage.
  // val: sample (low 16 bits) for PCM, rate for FMT, code (low 3 bits) for ERR.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] val;
    logic [1:0]  chans;
  } evt_t;

endpackage

[rtl/wps_front.sv]
// Byte parser: walks RIFF/WAVE headers and turns bytes into events.
module wps_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_start,
  input  logic          full,
  output logic          push,
  output wps_pkg::evt_t push_evt
);

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_FMT  = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_ENDQ = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] bits_field, bits_field_next;
  logic [1:0]  stream_channels, stream_channels_next;
  logic [31:0] rate_field, rate_field_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [23:0] frame_bytes, frame_bytes_next;
  logic        format_seen, format_seen_next;

  logic          accept;
  logic          fire;
  wps_pkg::evt_t evt;
  logic [16:0]   pair_sum;
  logic [16:0]   pair_adj;
  logic [15:0]   sample;
  logic          frame_done;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && fire;
  assign push_evt = evt;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    tag_shift_next       = tag_shift;
    chunk_size_next      = chunk_size;
    format_code_next     = format_code;
    bits_field_next      = bits_field;
    stream_channels_next = stream_channels;
    rate_field_next      = rate_field;
    data_remaining_next  = data_remaining;
    frame_bytes_next     = frame_bytes;
    format_seen_next     = format_seen;
    if (in_start) begin
      phase_next           = PH_HEAD;
      byte_count_next      = '0;
      tag_shift_next       = '0;
      chunk_size_next      = '0;
      format_code_next     = '0;
      bits_field_next      = '0;
      stream_channels_next = '0;
      rate_field_next      = '0;
      data_remaining_next  = '0;
      frame_bytes_next     = '0;
      format_seen_next     = 1'b0;
    end

    fire = 1'b0;
    evt  = '0;

    // stereo average, truncating toward zero
    pair_sum = {frame_bytes_next[15], frame_bytes_next[15:0]}
             + {in_byte[7], in_byte, frame_bytes_next[23:16]};
    pair_adj = pair_sum + {16'd0, pair_sum[16]};
    if (stream_channels_next == 2'd2) begin
      sample     = pair_adj[16:1];
      frame_done = (byte_count_next == 4'd3);
    end else begin
      sample     = {in_byte, frame_bytes_next[7:0]};
      frame_done = (byte_count_next == 4'd1);
    end

    case (phase_next)
      PH_HEAD: begin
        tag_shift_next = {in_byte, tag_shift_next[31:8]};
        if (byte_count_next == 4'd3 && tag_shift_next != wps_pkg::TAG_RIFF) begin
          fire = 1'b1;
          evt.kind = wps_pkg::EVT_ERR;
          evt.val  = {29'd0, wps_pkg::ERR_TAG};
          phase_next = PH_DONE;
        end else if (byte_count_next == 4'd11) begin
          if (tag_shift_next != wps_pkg::TAG_WAVE) begin
            fire = 1'b1;
            evt.kind = wps_pkg::EVT_ERR;
            evt.val  = {29'd0, wps_pkg::ERR_TAG};
            phase_next = PH_DONE;
          end else begin
            phase_next      = PH_HDR;
            byte_count_next = '0;
          end
        end else begin
          byte_count_next = byte_count_next + 4'd1;
        end
      end
      PH_HDR: begin
        if (byte_count_next < 4'd4) begin
          tag_shift_next = {in_byte, tag_shift_next[31:8]};
        end else begin
          chunk_size_next = {in_byte, chunk_size_next[31:8]};
        end
        if (byte_count_next != 4'd7) begin
          byte_count_next = byte_count_next + 4'd1;
        end else begin
          byte_count_next = '0;
          if (tag_shift_next == wps_pkg::TAG_FMT) begin
            if (chunk_size_next < 32'd16) begin
              fire = 1'b1;
              evt.kind = wps_pkg::EVT_ERR;
              evt.val  = {29'd0, wps_pkg::ERR_SHORT};
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_FMT;
            end
          end else if (tag_shift_next == wps_pkg::TAG_DATA) begin
            if (!format_seen_next) begin
              fire = 1'b1;
              evt.kind = wps_pkg::EVT_ERR;
              evt.val  = {29'd0, wps_pkg::ERR_NO_FMT};
              phase_next = PH_DONE;
            end else begin
              data_remaining_next = chunk_size_next;
              frame_bytes_next    = '0;
              if (chunk_size_next == 32'd0) begin
                fire = 1'b1;
                evt.kind = wps_pkg::EVT_END;
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else if (chunk_size_next != 32'd0) begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        chunk_size_next = chunk_size_next - 32'd1;
        if (chunk_size_next == 32'd0) begin
          phase_next      = PH_HDR;
          byte_count_next = '0;
        end
      end
      PH_FMT: begin
        if (byte_count_next < 4'd2) begin
          format_code_next = {in_byte, format_code_next[15:8]};
        end else if (byte_count_next < 4'd4) begin
          tag_shift_next = {16'd0, in_byte, tag_shift_next[15:8]};
        end else if (byte_count_next < 4'd8) begin
          rate_field_next = {in_byte, rate_field_next[31:8]};
        end else if (byte_count_next >= 4'd14) begin
          bits_field_next = {in_byte, bits_field_next[15:8]};
        end
        if (byte_count_next != 4'd15) begin
          byte_count_next = byte_count_next + 4'd1;
        end else begin
          byte_count_next = '0;
          if (format_code_next != 16'd1 || bits_field_next != 16'd16) begin
            fire = 1'b1;
            evt.kind = wps_pkg::EVT_ERR;
            evt.val  = {29'd0, wps_pkg::ERR_NOT_PCM};
            phase_next = PH_DONE;
          end else if (tag_shift_next != 32'd1 && tag_shift_next != 32'd2) begin
            fire = 1'b1;
            evt.kind = wps_pkg::EVT_ERR;
            evt.val  = {29'd0, wps_pkg::ERR_CHANNELS};
            phase_next = PH_DONE;
          end else begin
            stream_channels_next = tag_shift_next[1:0];
            format_seen_next     = 1'b1;
            fire = 1'b1;
            evt.kind  = wps_pkg::EVT_FMT;
            evt.val   = rate_field_next;
            evt.chans = tag_shift_next[1:0];
            chunk_size_next = chunk_size_next - 32'd16;
            phase_next = (chunk_size_next != 32'd0) ? PH_SKIP : PH_HDR;
          end
        end
      end
      PH_DATA: begin
        data_remaining_next = data_remaining_next - 32'd1;
        if (!frame_done) begin
          case (byte_count_next[1:0])
            2'd0:    frame_bytes_next[7:0]   = in_byte;
            2'd1:    frame_bytes_next[15:8]  = in_byte;
            default: frame_bytes_next[23:16] = in_byte;
          endcase
          byte_count_next = byte_count_next + 4'd1;
          if (data_remaining_next == 32'd0) begin
            fire = 1'b1;
            evt.kind = wps_pkg::EVT_END;
            phase_next = PH_DONE;
          end
        end else begin
          fire = 1'b1;
          evt.kind = wps_pkg::EVT_PCM;
          evt.val  = {16'd0, sample};
          byte_count_next  = '0;
          frame_bytes_next = '0;
          if (data_remaining_next == 32'd0) begin
            phase_next = PH_ENDQ;  // end goes out on the next beat
          end
        end
      end
      PH_ENDQ: begin
        fire = 1'b1;
        evt.kind = wps_pkg::EVT_END;
        phase_next = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEAD;
      byte_count      <= '0;
      tag_shift       <= '0;
      chunk_size      <= '0;
      format_code     <= '0;
      bits_field      <= '0;
      stream_channels <= '0;
      rate_field      <= '0;
      data_remaining  <= '0;
      frame_bytes     <= '0;
      format_seen     <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      tag_shift       <= tag_shift_next;
      chunk_size      <= chunk_size_next;
      format_code     <= format_code_next;
      bits_field      <= bits_field_next;
      stream_channels <= stream_channels_next;
      rate_field      <= rate_field_next;
      data_remaining  <= data_remaining_next;
      frame_bytes     <= frame_bytes_next;
      format_seen     <= format_seen_next;
    end
  end

endmodule

[rtl/wps_queue.sv]
// Small event FIFO between the parser and the output stage.
module wps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wps_pkg::evt_t push_evt,
  output logic          full,
  input  logic          pop,
  output wps_pkg::evt_t pop_evt,
  output logic          empty
);

  wps_pkg::evt_t             entries [wps_pkg::QUEUE_DEPTH];
  logic [wps_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [wps_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [wps_pkg::QUEUE_AW:0]   count;

  assign full    = (count == (wps_pkg::QUEUE_AW+1)'(wps_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_evt = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/wps_back.sv]
// Output stage: volume scaling and the registered output beat.
module wps_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [14:0]   cfg_wdata,
  input  logic          empty,
  input  wps_pkg::evt_t pop_evt,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [71:0]   out_data
);

  logic [14:0]        volume;
  logic signed [30:0] product;
  logic [15:0]        scaled;
  logic [71:0]        data_next;

  assign pop = !empty && (!out_valid || out_ready);

  assign product = $signed(pop_evt.val[15:0]) * $signed({1'b0, volume});
  assign scaled  = product[30:wps_pkg::Q_SHIFT];  // arithmetic shift, floor

  always_comb begin
    data_next = '0;
    case (pop_evt.kind)
      wps_pkg::EVT_PCM: data_next[31:0]  = {scaled, 16'd0};
      wps_pkg::EVT_FMT: begin
        data_next[63:32] = pop_evt.val;
        data_next[65:64] = pop_evt.chans;
      end
      wps_pkg::EVT_ERR: data_next[68:66] = pop_evt.val[2:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= wps_pkg::VOLUME_RESET;
    end else if (cfg_we) begin
      volume <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= pop_evt.kind;
      out_data <= data_next;
    end
  end

endmodule

[rtl/wav_pcm_stream_decoder_core.sv]
// Top level of the WAV PCM stream decoder.
// Usage:
//   s_axis carries the file one byte per beat: tdata is the byte, tuser set
//   restarts parsing with that byte as offset zero.
//   m_axis carries events: tuser is the kind (sample, format, end, error),
//   tdata holds the payload fields of that kind, zero elsewhere.
//   cfg_we/cfg_wdata write the Q15 volume; write it only while idle.
// Throughput: one byte per cycle sustained while the event queue is not
// full. The parser updates its header state once per accepted byte; a
// 4-entry event queue sits between the parser and the output register,
// and the single 16x16 volume multiply sits in the output stage.
// Path: an event caused by a byte is written into the queue, then into
// the output register, and is then valid on m_axis.
// Stall: when m_axis_tready is low the output beat holds; the queue fills
// and s_axis_tready drops once all four entries are taken.
// Reset: clears the parser, empties the queue, drops m_axis_tvalid and sets
// the volume to 8192 (0.25).
module wav_pcm_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tuser,   // [0] start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] pcm_slot, [63:32] rate_hz,
                                      // [65:64] channel_count, [68:66] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata       // volume_q15
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  wps_pkg::evt_t push_evt;
  wps_pkg::evt_t pop_evt;

  wps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_start (s_axis_tuser),
    .full     (q_full),
    .push     (push),
    .push_evt (push_evt)
  );

  wps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .full     (q_full),
    .pop      (pop),
    .pop_evt  (pop_evt),
    .empty    (q_empty)
  );

  wps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .empty     (q_empty),
    .pop_evt   (pop_evt),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("event pushed into full queue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == wps_pkg::EVT_ERR) |-> m_axis_tdata[65:0] == '0)
    else $error("error beat carries sample or format data");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_empty))
    else $error("pop from empty queue");

endmodule

[test/wav_event_checker.sv]
// Checker for the WAV PCM stream decoder: predicts events from accepted bytes and compares.
`timescale 1ns / 1ps

module wav_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  output int          fail_total,
  output int          pending_count,
  output int          bytes_seen,
  output int          pcm_events,
  output int          format_events,
  output int          end_events,
  output int          error_events
);

  localparam logic [2:0] ST_RIFF        = 3'd0;
  localparam logic [2:0] ST_CHUNK_HDR   = 3'd1;
  localparam logic [2:0] ST_FMT_BODY    = 3'd2;
  localparam logic [2:0] ST_SKIP        = 3'd3;
  localparam logic [2:0] ST_SAMPLES     = 3'd4;
  localparam logic [2:0] ST_END_PENDING = 3'd5;
  localparam logic [2:0] ST_IDLE        = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] slot;
    logic [31:0] rate;
    logic [1:0]  chans;
    logic [2:0]  code;
  } wav_event_t;

  wav_event_t events_due[$];

  // decoder model state
  logic [2:0]   phase;
  logic [31:0]  byte_pos;
  logic [31:0]  tag_window;
  logic [31:0]  chunk_left;
  logic [15:0]  fmt_code;
  logic [15:0]  fmt_bits;
  logic [15:0]  fmt_chans;
  logic [31:0]  fmt_rate;
  logic [1:0]   src_chans;
  logic [31:0]  data_left;
  logic [23:0]  frame_acc;
  logic         fmt_ok;
  logic [14:0]  gain_q15;

  logic         ev_valid;
  wav_event_t   ev_out;

  task automatic clear_parse();
    phase      = ST_RIFF;
    byte_pos   = '0;
    tag_window = '0;
    chunk_left = '0;
    fmt_code   = '0;
    fmt_bits   = '0;
    fmt_chans  = '0;
    fmt_rate   = '0;
    src_chans  = '0;
    data_left  = '0;
    frame_acc  = '0;
    fmt_ok     = 1'b0;
  endtask

  task automatic raise_error(input logic [2:0] code);
    ev_valid     = 1'b1;
    ev_out.kind  = wps_pkg::EVT_ERR;
    ev_out.code  = code;
    phase        = ST_IDLE;
  endtask

  task automatic raise_end();
    ev_valid    = 1'b1;
    ev_out.kind = wps_pkg::EVT_END;
    phase       = ST_IDLE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    logic signed [15:0] left_s, right_s;
    int mix, prod, frame_len;
    ev_valid = 1'b0;
    ev_out   = '0;
    if (sof) clear_parse();
    case (phase)
      ST_RIFF: begin
        tag_window = {b, tag_window[31:8]};
        if (byte_pos == 3 && tag_window != wps_pkg::TAG_RIFF) begin
          raise_error(wps_pkg::ERR_TAG);
        end else if (byte_pos == 11) begin
          if (tag_window != wps_pkg::TAG_WAVE) begin
            raise_error(wps_pkg::ERR_TAG);
          end else begin
            phase    = ST_CHUNK_HDR;
            byte_pos = '0;
          end
        end else begin
          byte_pos++;
        end
      end
      ST_CHUNK_HDR: begin
        if (byte_pos < 4) tag_window = {b, tag_window[31:8]};
        else chunk_left = {b, chunk_left[31:8]};
        byte_pos++;
        if (byte_pos == 8) begin
          byte_pos = '0;
          if (tag_window == wps_pkg::TAG_FMT) begin
            if (chunk_left < 16) raise_error(wps_pkg::ERR_SHORT);
            else phase = ST_FMT_BODY;
          end else if (tag_window == wps_pkg::TAG_DATA) begin
            if (!fmt_ok) begin
              raise_error(wps_pkg::ERR_NO_FMT);
            end else begin
              data_left = chunk_left;
              frame_acc = '0;
              if (data_left == 0) raise_end();
              else phase = ST_SAMPLES;
            end
          end else if (chunk_left != 0) begin
            phase = ST_SKIP;
          end
        end
      end
      ST_SKIP: begin
        chunk_left--;
        if (chunk_left == 0) begin
          phase    = ST_CHUNK_HDR;
          byte_pos = '0;
        end
      end
      ST_FMT_BODY: begin
        if (byte_pos < 2) fmt_code = {b, fmt_code[15:8]};
        else if (byte_pos < 4) fmt_chans = {b, fmt_chans[15:8]};
        else if (byte_pos < 8) fmt_rate = {b, fmt_rate[31:8]};
        else if (byte_pos >= 14) fmt_bits = {b, fmt_bits[15:8]};
        byte_pos++;
        if (byte_pos == 16) begin
          byte_pos = '0;
          if (fmt_code != 16'd1 || fmt_bits != 16'd16) begin
            raise_error(wps_pkg::ERR_NOT_PCM);
          end else if (fmt_chans != 16'd1 && fmt_chans != 16'd2) begin
            raise_error(wps_pkg::ERR_CHANNELS);
          end else begin
            src_chans    = fmt_chans[1:0];
            fmt_ok       = 1'b1;
            ev_valid     = 1'b1;
            ev_out.kind  = wps_pkg::EVT_FMT;
            ev_out.rate  = fmt_rate;
            ev_out.chans = src_chans;
            chunk_left   = chunk_left - 32'd16;
            phase        = (chunk_left != 0) ? ST_SKIP : ST_CHUNK_HDR;
          end
        end
      end
      ST_SAMPLES: begin
        frame_len = (src_chans == 2'd2) ? 4 : 2;
        data_left--;
        if (byte_pos + 1 < frame_len) begin
          frame_acc[8*byte_pos[1:0] +: 8] = b;
          byte_pos++;
        end else begin
          if (frame_len == 4) begin
            left_s  = frame_acc[15:0];
            right_s = {b, frame_acc[23:16]};
            // stereo mix truncates toward zero
            mix = (int'(left_s) + int'(right_s)) / 2;
          end else begin
            left_s = {b, frame_acc[7:0]};
            mix    = int'(left_s);
          end
          prod        = mix * int'({17'd0, gain_q15});
          prod        = prod >>> wps_pkg::Q_SHIFT;
          ev_valid    = 1'b1;
          ev_out.kind = wps_pkg::EVT_PCM;
          ev_out.slot = {prod[15:0], 16'h0000};
          byte_pos    = '0;
          frame_acc   = '0;
        end
        // a sample on the last data byte pushes the end event to the next byte
        if (data_left == 0) begin
          if (ev_valid) phase = ST_END_PENDING;
          else raise_end();
        end
      end
      ST_END_PENDING: raise_end();
      default: ;
    endcase
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    fail_total++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  task automatic check_beat();
    wav_event_t want;
    if (events_due.size() == 0) begin
      log_mismatch("unexpected output beat (kind)", 32'(m_axis_tuser), 32'h0);
    end else begin
      want = events_due.pop_front();
      if (m_axis_tuser != want.kind)
        log_mismatch("event kind", 32'(m_axis_tuser), 32'(want.kind));
      if (m_axis_tdata[31:0] != want.slot) log_mismatch("pcm slot", m_axis_tdata[31:0], want.slot);
      if (m_axis_tdata[63:32] != want.rate)
        log_mismatch("sample rate", m_axis_tdata[63:32], want.rate);
      if (m_axis_tdata[65:64] != want.chans)
        log_mismatch("channel count", 32'(m_axis_tdata[65:64]), 32'(want.chans));
      if (m_axis_tdata[68:66] != want.code)
        log_mismatch("error code", 32'(m_axis_tdata[68:66]), 32'(want.code));
      if (m_axis_tdata[71:69] != 3'd0)
        log_mismatch("tdata pad", 32'(m_axis_tdata[71:69]), 32'h0);
      case (want.kind)
        wps_pkg::EVT_PCM: pcm_events++;
        wps_pkg::EVT_FMT: format_events++;
        wps_pkg::EVT_END: end_events++;
        default: error_events++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      gain_q15 = wps_pkg::VOLUME_RESET;
      events_due.delete();
    end else begin
      if (cfg_we) gain_q15 = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_seen++;
        decode_byte(s_axis_tdata, s_axis_tuser);
        if (ev_valid) events_due.push_back(ev_out);
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
    pending_count = events_due.size();
  end

endmodule

[test/tb_top.sv]
// Top of the WAV PCM stream decoder testbench: builds WAV byte streams and drives the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } feed_beat_t;

  typedef struct {
    logic [15:0] chans;
    logic [15:0] fcode;
    logic [15:0] bits;
    logic [31:0] rate;
    int          fmt_len;
    int          data_len;
    int          sent_len;
    int          junk_pre;
    int          junk_post;
    int          trailing;
    bit          two_fmt;
    bit          riff_bad;
    bit          wave_bad;
    bit          data_first;
    bit          pin;
  } wav_plan_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = 15'd0;

  int fail_total, pending_count, bytes_seen;
  int pcm_events, format_events, end_events, error_events;

  feed_beat_t feed_q[$];
  logic       first_byte = 1'b0;
  int         bytes_queued = 0;
  bit         hold_wanted = 1'b0;
  int         cycle_count = 0;

  always #2 clk = ~clk;

  wav_pcm_stream_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  wav_event_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_total    (fail_total),
    .pending_count (pending_count),
    .bytes_seen    (bytes_seen),
    .pcm_events    (pcm_events),
    .format_events (format_events),
    .end_events    (end_events),
    .error_events  (error_events)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_count, pending_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // byte sender: bursts of random length with random gaps
  initial begin : sender
    int burst_left, gap_left;
    feed_beat_t beat;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (feed_q.size() != 0) begin
          beat = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat.data;
          s_axis_tuser  <= beat.sof;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // event receiver: stall pattern that changes mode, plus one long hold-off on request
  initial begin : receiver
    rx_mode_t rx_mode;
    int mode_left, hold_left;
    bit hold_done;
    rx_mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:  m_axis_tready <= 1'b1;
          RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SLOW:  m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:  m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      feed_q.push_back({first_byte, v[8*i +: 8]});
      first_byte = 1'b0;
      bytes_queued++;
    end
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_le($urandom(), 1);
  endtask

  task automatic push_junk(input int len);
    // first tag byte 'J' keeps it clear of fmt and data
    push_le({24'($urandom()), 8'h4A}, 4);
    push_le(len, 4);
    push_random(len);
  endtask

  task automatic push_fmt(input int len, input logic [15:0] fcode, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] bits);
    push_le(wps_pkg::TAG_FMT, 4);
    push_le(len, 4);
    if (len < 16) begin
      push_random(len);
    end else begin
      push_le(32'(fcode), 2);
      push_le(32'(chans), 2);
      push_le(rate, 4);
      push_random(6);  // byte rate, block align
      push_le(32'(bits), 2);
      push_random(len - 16);
    end
  endtask

  function automatic logic [31:0] tag_flaw();
    return 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
  endfunction

  task automatic send_wav(input wav_plan_t p);
    logic [15:0] word;
    first_byte = 1'b1;
    push_le(p.riff_bad ? (wps_pkg::TAG_RIFF ^ tag_flaw()) : wps_pkg::TAG_RIFF, 4);
    push_random(4);
    push_le(p.wave_bad ? (wps_pkg::TAG_WAVE ^ tag_flaw()) : wps_pkg::TAG_WAVE, 4);
    if (p.data_first) begin
      push_le(wps_pkg::TAG_DATA, 4);
      push_le(p.data_len, 4);
    end
    if (p.junk_pre >= 0) push_junk(p.junk_pre);
    if (p.two_fmt)
      push_fmt(16 + $urandom_range(0, 3), 16'd1, 16'($urandom_range(1, 2)), $urandom(), 16'd16);
    push_fmt(p.fmt_len, p.fcode, p.chans, p.rate, p.bits);
    if (p.junk_post >= 0) push_junk(p.junk_post);
    push_le(wps_pkg::TAG_DATA, 4);
    push_le(p.data_len, 4);
    for (int k = 0; 2 * k < p.sent_len; k++) begin
      if (p.pin && k < 12) begin
        case (k)
          0, 1:    word = 16'h8000;
          2, 3:    word = 16'h7FFF;
          4:       word = 16'hFFFF;
          5:       word = 16'h0000;
          6:       word = 16'h0001;
          7:       word = 16'hFFFE;
          8:       word = 16'h7FFF;
          9:       word = 16'h8000;
          10:      word = 16'h0003;
          default: word = 16'hFFFB;
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       word = 16'h8000;
          1:       word = 16'h7FFF;
          default: word = 16'($urandom());
        endcase
      end
      push_le(32'(word), (p.sent_len - 2 * k >= 2) ? 2 : 1);
    end
    push_random(p.trailing);
  endtask

  function automatic wav_plan_t random_plan();
    wav_plan_t p;
    p.chans = 16'($urandom_range(1, 2));
    p.fcode = 16'd1;
    p.bits  = 16'd16;
    case ($urandom_range(0, 5))
      0:       p.rate = 32'd0;
      1:       p.rate = 32'hFFFF_FFFF;
      2:       p.rate = 32'd44100;
      3:       p.rate = 32'd48000;
      default: p.rate = $urandom();
    endcase
    p.fmt_len    = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : 16;
    p.data_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 160) : $urandom_range(0, 48);
    p.sent_len   = p.data_len;
    p.junk_pre   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : -1;
    p.junk_post  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : -1;
    p.trailing   = $urandom_range(1, 4);
    p.two_fmt    = ($urandom_range(0, 7) == 0);
    p.riff_bad   = 1'b0;
    p.wave_bad   = 1'b0;
    p.data_first = 1'b0;
    p.pin        = 1'b0;
    return p;
  endfunction

  function automatic wav_plan_t with_flaw(input wav_plan_t p, input int kind);
    case (kind)
      0: p.riff_bad = 1'b1;
      1: p.wave_bad = 1'b1;
      2: p.data_first = 1'b1;
      3: p.fmt_len = $urandom_range(0, 15);
      4: begin
        p.fcode = 16'($urandom());
        if (p.fcode == 16'd1) p.fcode = 16'd0;
      end
      5: begin
        p.bits = 16'($urandom_range(0, 32));
        if (p.bits == 16'd16) p.bits = 16'd24;
      end
      6: p.chans = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(3, 65535));
      default: begin
        // file may be cut short inside the data chunk; the next file restarts the parser
        p.sent_len = $urandom_range(0, p.data_len);
        p.trailing = 0;
      end
    endcase
    return p;
  endfunction

  task automatic random_files(input int budget);
    int stop_at, roll, n;
    stop_at = bytes_queued + budget;
    while (bytes_queued < stop_at) begin
      roll = $urandom_range(0, 19);
      if (roll < 3) begin
        first_byte = 1'b1;
        n = $urandom_range(4, 30);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 15) == 0) first_byte = 1'b1;
          push_random(1);
        end
      end else if (roll < 5) begin
        send_wav(with_flaw(random_plan(), $urandom_range(0, 7)));
      end else begin
        send_wav(random_plan());
      end
    end
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || s_axis_tvalid || pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_volume(input logic [14:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : main
    wav_plan_t p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset volume: pinned extremes, sizes at frame edges, chunk walking, every error
    p = random_plan();
    p.pin = 1'b1;
    p.chans = 16'd1;
    p.data_len = 24;
    p.sent_len = 24;
    p.rate = 32'd0;
    p.junk_pre = -1;
    p.junk_post = -1;
    p.two_fmt = 1'b0;
    p.fmt_len = 16;
    p.trailing = 2;
    send_wav(p);
    p.chans = 16'd2;
    p.data_len = 27;
    p.sent_len = 27;
    p.rate = 32'hFFFF_FFFF;
    send_wav(p);
    p.data_len = 0;
    p.sent_len = 0;
    send_wav(p);
    p = random_plan();
    p.junk_pre = 3;
    p.junk_post = 0;
    p.fmt_len = 17;
    p.two_fmt = 1'b1;
    send_wav(p);
    for (int k = 0; k < 8; k++) send_wav(with_flaw(random_plan(), k));
    p = random_plan();
    p.chans = 16'd3;
    send_wav(p);
    // long receiver hold-off while the sender keeps offering bytes
    hold_wanted = 1'b1;
    p = random_plan();
    p.chans = 16'd1;
    p.data_len = 40;
    p.sent_len = 40;
    send_wav(p);
    wait_idle();

    set_volume(15'h7FFF);
    p = random_plan();
    p.pin = 1'b1;
    p.chans = 16'd2;
    p.data_len = 24;
    p.sent_len = 24;
    send_wav(p);
    p.chans = 16'd1;
    send_wav(p);
    wait_idle();

    set_volume(15'd0);
    random_files(40);
    wait_idle();

    set_volume(15'd1);
    random_files(40);
    wait_idle();

    set_volume(15'($urandom_range(2, 32766)));
    random_files(40);
    wait_idle();
    repeat (12) @(negedge clk);

    $display("covered %0d file bytes: %0d samples, %0d format, %0d end, %0d error events",
             bytes_seen, pcm_events, format_events, end_events, error_events);
    $display("volume at reset value, full scale, zero, one and random; one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_total == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", fail_total);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[wav_pcm_stream_decoder_core.f]
rtl/wps_pkg.sv
rtl/wps_front.sv
rtl/wps_queue.sv
rtl/wps_back.sv
rtl/wav_pcm_stream_decoder_core.sv
test/wav_event_checker.sv
test/tb_top.sv
